### rtl/core/keyboard_report_number_entry_macros.svh
// Assertion macros for the number entry RTL
`ifndef KEYBOARD_REPORT_NUMBER_ENTRY_MACROS_SVH
`define KEYBOARD_REPORT_NUMBER_ENTRY_MACROS_SVH

// Same-cycle implication, held off during reset
`define KRNE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("krne assertion failed");

// Next-cycle implication, held off during reset
`define KRNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("krne assertion failed");

`endif

### rtl/core/krne_pkg.sv
// Types, codes and key classification for the keyboard number entry block
package krne_pkg;

   localparam int KEY_W        = 8;
   localparam int INPUT_SLOTS  = 6;
   localparam int ACC_W        = 64;
   localparam int OP_W         = 2;
   localparam int DIGIT_BITS   = 4;
   localparam int DIV_STEPS    = ACC_W / DIGIT_BITS;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   // request operations
   localparam logic [OP_W-1:0] OP_PARSE  = 2'd0;
   localparam logic [OP_W-1:0] OP_RESYNC = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // HID usage codes
   localparam logic [KEY_W-1:0] KEY_MAIN_1    = 8'h1E;
   localparam logic [KEY_W-1:0] KEY_MAIN_9    = 8'h26;
   localparam logic [KEY_W-1:0] KEY_MAIN_0    = 8'h27;
   localparam logic [KEY_W-1:0] KEY_ENTER     = 8'h28;
   localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h2A;
   localparam logic [KEY_W-1:0] KEY_KP_ENTER  = 8'h58;
   localparam logic [KEY_W-1:0] KEY_KP_1      = 8'h59;
   localparam logic [KEY_W-1:0] KEY_KP_9      = 8'h61;
   localparam logic [KEY_W-1:0] KEY_KP_0      = 8'h62;

   // what a newly pressed key does
   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_DIGIT = 2'd1,
      ACT_BACK  = 2'd2,
      ACT_ENTER = 2'd3
   } key_action_type;

   typedef struct packed {
      key_action_type        action;
      logic [DIGIT_BITS-1:0] digit;
   } key_class_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic step;
      logic div_start;
      logic div_step;
      logic store_keys;
      logic clear_keys;
      logic emit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      key_action_type  action;
      logic            last_slot;
      logic            div_last;
      logic            enter_seen;
      logic            out_free;
   } dp_status_type;

   function automatic key_class_type classify_key(input logic [KEY_W-1:0] code);
      key_class_type c;
      c.action = ACT_NONE;
      c.digit  = '0;
      if (code >= KEY_MAIN_1 && code <= KEY_MAIN_9) begin
         c.action = ACT_DIGIT;
         c.digit  = DIGIT_BITS'(code - KEY_MAIN_1 + 8'd1);
      end else if (code == KEY_MAIN_0 || code == KEY_KP_0) begin
         c.action = ACT_DIGIT;
      end else if (code >= KEY_KP_1 && code <= KEY_KP_9) begin
         c.action = ACT_DIGIT;
         c.digit  = DIGIT_BITS'(code - KEY_KP_1 + 8'd1);
      end else if (code == KEY_BACKSPACE) begin
         c.action = ACT_BACK;
      end else if (code == KEY_ENTER || code == KEY_KP_ENTER) begin
         c.action = ACT_ENTER;
      end
      return c;
   endfunction

endpackage

### rtl/core/krne_ctrl.sv
// Controller state machine: sequences slot walk, divide, key store and emit
module krne_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic [krne_pkg::OP_W-1:0]    req_op,
   output logic                         req_tready,
   input  krne_pkg::dp_status_type      status,
   output krne_pkg::ctrl_cmd_type       cmd
);
   import krne_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_STORE = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_op == OP_PARSE) ? ST_SCAN : ST_STORE;
            end
         end
         ST_SCAN: begin
            if (status.action == ACT_BACK) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.step = 1'b1;
               if (status.last_slot) state_in = ST_STORE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = status.last_slot ? ST_STORE : ST_SCAN;
         end
         ST_STORE: begin
            cmd.store_keys = (status.op == OP_PARSE) || (status.op == OP_RESYNC);
            cmd.clear_keys = (status.op == OP_CLEAR);
            state_in = (status.op == OP_PARSE && status.enter_seen) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/krne_dp.sv
// Datapath: report slots, held keys, accumulator, divide-by-ten unit, result register
module krne_dp #(
   parameter int KEY_SLOTS = 6
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic [krne_pkg::OP_W-1:0]                            req_op,
   input  logic [krne_pkg::INPUT_SLOTS*krne_pkg::KEY_W-1:0]     req_slots,
   input  krne_pkg::ctrl_cmd_type                               cmd,
   output krne_pkg::dp_status_type                              status,
   input  logic                                                 rsp_tready,
   output logic                                                 rsp_tvalid,
   output logic [krne_pkg::ACC_W-1:0]                           rsp_data
);
   import krne_pkg::*;

   localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);
   localparam logic [DIV_CNT_W-1:0] LAST_DIV = DIV_CNT_W'(DIV_STEPS - 1);

   logic [KEY_W-1:0]     cur_keys_ff  [KEY_SLOTS];
   logic [KEY_W-1:0]     prev_keys_ff [KEY_SLOTS];
   logic [KEY_W-1:0]     req_keys     [KEY_SLOTS];
   logic [OP_W-1:0]      op_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 enter_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_W-1:0]     acc_in;
   logic [ACC_W-1:0]     work_ff;
   logic [ACC_W-1:0]     work_in;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [DIGIT_BITS-1:0] rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 neg_ff;
   logic                 rsp_valid_ff;
   logic [ACC_W-1:0]     rsp_data_ff;
   logic [KEY_W-1:0]     code;
   logic                 held;
   key_class_type        kclass;
   logic [DIGIT_BITS-1:0] qbits;

   // report slots past the input fields read as empty
   for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_req
      if (k < INPUT_SLOTS) begin : g_used
         assign req_keys[k] = req_slots[k*KEY_W +: KEY_W];
      end else begin : g_empty
         assign req_keys[k] = '0;
      end
   end

   // current slot and its test against the previous report
   assign code = cur_keys_ff[idx_ff];
   always_comb begin
      held = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (prev_keys_ff[j] == code) held = 1'b1;
      end
   end

   always_comb begin
      kclass = classify_key(code);
      if (code == '0 || held) kclass.action = ACT_NONE;
   end

   // restoring divide by ten, one nibble of the dividend per step, top nibble first
   always_comb begin
      logic [DIGIT_BITS:0] t;
      rem_in = rem_ff;
      qbits  = '0;
      for (int b = DIGIT_BITS - 1; b >= 0; b--) begin
         t = {rem_in, work_ff[ACC_W - DIGIT_BITS + b]};
         if (t >= 5'd10) begin
            qbits[b] = 1'b1;
            rem_in   = DIGIT_BITS'(t - 5'd10);
         end else begin
            qbits[b] = 1'b0;
            rem_in   = t[DIGIT_BITS-1:0];
         end
      end
      work_in = {work_ff[ACC_W-DIGIT_BITS-1:0], qbits};
   end

   // accumulator update
   always_comb begin
      acc_in = acc_ff;
      if (cmd.emit) begin
         acc_in = '0;
      end else if (cmd.step && kclass.action == ACT_DIGIT) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + ACC_W'(kclass.digit);
      end else if (cmd.div_step && div_cnt_ff == LAST_DIV) begin
         acc_in = neg_ff ? (ACC_W'(0) - work_in) : work_in;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < KEY_SLOTS; j++) prev_keys_ff[j] <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         enter_ff     <= 1'b0;
         idx_ff       <= '0;
         div_cnt_ff   <= '0;
         op_ff        <= OP_PARSE;
      end else begin
         acc_ff <= acc_in;
         if (cmd.load_req) begin
            op_ff    <= req_op;
            idx_ff   <= '0;
            enter_ff <= 1'b0;
         end
         if (cmd.step) begin
            idx_ff <= idx_ff + 1'b1;
            if (kclass.action == ACT_ENTER) enter_ff <= 1'b1;
         end
         if (cmd.div_start) div_cnt_ff <= '0;
         if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (div_cnt_ff == LAST_DIV) idx_ff <= idx_ff + 1'b1;
         end
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (cmd.store_keys) prev_keys_ff[j] <= cur_keys_ff[j];
            else if (cmd.clear_keys) prev_keys_ff[j] <= '0;
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         for (int j = 0; j < KEY_SLOTS; j++) cur_keys_ff[j] <= req_keys[j];
      end
      if (cmd.div_start) begin
         neg_ff  <= acc_ff[ACC_W-1];
         work_ff <= acc_ff[ACC_W-1] ? (ACC_W'(0) - acc_ff) : acc_ff;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
      if (cmd.emit) rsp_data_ff <= acc_ff;
   end

   assign status.op         = op_ff;
   assign status.action     = kclass.action;
   assign status.last_slot  = (idx_ff == LAST_IDX);
   assign status.div_last   = (div_cnt_ff == LAST_DIV);
   assign status.enter_seen = enter_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### rtl/core/keyboard_report_number_entry.sv
// Top level of the keyboard report number entry block
//
// Request channel (req_): one boot keyboard report per request. req_tuser
// carries the operation (parse, resync stored keys, clear stored keys) and
// req_tdata the key slots. A parse walks the slots one per cycle, pausing
// for a divide on each newly pressed backspace, builds a decimal value from
// newly pressed digit keys and, if a newly pressed enter key was among them,
// sends the value after the walk on the result channel (rsp_) and clears it.
// Steps: the request is taken, the key slots are walked, each backspace runs
// the divide-by-ten unit (it retires four quotient bits of the 64-bit
// magnitude a cycle), the slots are stored and, when enter was seen, the
// result register is loaded. Resync and clear take the request and then
// store or clear the slots. One request is worked at a time.
// Reset clears the stored keys, the accumulator and any pending result.
// The result sits in an output register: a stalled receiver holds it there
// while the next request is taken and worked; only a second result waits,
// in its final state, until the register frees.
module keyboard_report_number_entry #(
   parameter int KEY_SLOTS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key_slot_0 .. key_slot_5, 8 bits each
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // entered_number
);
   import krne_pkg::*;

   `include "keyboard_report_number_entry_macros.svh"

   ctrl_cmd_type  cmd;
   dp_status_type status;

   krne_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   krne_dp #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_slots  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_tdata)
   );

   // a taken request keeps the block busy the next cycle
   `KRNE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // a new result never overwrites one still waiting
   `KRNE_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.emit, !rsp_tvalid || rsp_tready)
   // an emitted result shows up on the port
   `KRNE_ASSERT_NEXT(a_emit_visible, clock, reset, cmd.emit, rsp_tvalid)

endmodule

### test/keyboard_report_number_entry_tb.sv
// Self-checking testbench for the keyboard report number entry block
module keyboard_report_number_entry_tb;
   import krne_pkg::*;

   // op code that the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // empty slot and an unassigned usage code
   localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
   localparam logic [KEY_W-1:0] KEY_JUNK = 8'hFF;
   localparam int RANDOM_REQUESTS = 1600;
   localparam int DRAIN_CYCLES    = 20000;
   localparam int SETTLE_CYCLES   = 120;

   // running decimal entry: tracks held keys and accumulator, queues numbers due
   class number_tracker;
      logic [KEY_W-1:0] held_keys [INPUT_SLOTS];
      logic [ACC_W-1:0] accumulator;
      logic [ACC_W-1:0] pending_numbers [$];
      int               errors;

      function new();
         foreach (held_keys[j])
            held_keys[j] = KEY_NONE;
         accumulator = '0;
         errors = 0;
      endfunction

      function key_action_type decode_key(input logic [KEY_W-1:0] code,
                                          output logic [3:0] digit);
         digit = '0;
         if (code >= KEY_MAIN_1 && code <= KEY_MAIN_9) begin
            digit = 4'(code - KEY_MAIN_1 + 8'd1);
            return ACT_DIGIT;
         end
         if (code >= KEY_KP_1 && code <= KEY_KP_9) begin
            digit = 4'(code - KEY_KP_1 + 8'd1);
            return ACT_DIGIT;
         end
         if (code == KEY_MAIN_0 || code == KEY_KP_0)
            return ACT_DIGIT;
         if (code == KEY_BACKSPACE)
            return ACT_BACK;
         if (code == KEY_ENTER || code == KEY_KP_ENTER)
            return ACT_ENTER;
         return ACT_NONE;
      endfunction

      // update the state for one accepted request
      function void take_report(input logic [OP_W-1:0] op, input logic [47:0] keys);
         logic [KEY_W-1:0] code;
         logic [3:0]       digit;
         logic [ACC_W-1:0] mag;
         bit               enter_seen;
         bit               held;
         enter_seen = 0;
         case (op)
            OP_RESYNC: begin
               foreach (held_keys[j])
                  held_keys[j] = keys[8*j +: 8];
            end
            OP_CLEAR: begin
               foreach (held_keys[j])
                  held_keys[j] = KEY_NONE;
            end
            OP_PARSE: begin
               for (int i = 0; i < INPUT_SLOTS; i++) begin
                  code = keys[8*i +: 8];
                  held = 0;
                  foreach (held_keys[j])
                     if (held_keys[j] == code)
                        held = 1;
                  if (code != KEY_NONE && !held) begin
                     case (decode_key(code, digit))
                        ACT_DIGIT: accumulator = accumulator * 64'd10 + 64'(digit);
                        ACT_BACK: begin
                           // truncate toward zero on the signed value
                           if (accumulator[ACC_W-1]) begin
                              mag = -accumulator;
                              accumulator = -(mag / 64'd10);
                           end else begin
                              accumulator = accumulator / 64'd10;
                           end
                        end
                        ACT_ENTER: enter_seen = 1;
                        default: ;
                     endcase
                  end
               end
               foreach (held_keys[j])
                  held_keys[j] = keys[8*j +: 8];
               if (enter_seen) begin
                  pending_numbers.push_back(accumulator);
                  accumulator = '0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_number(input logic [ACC_W-1:0] got);
         logic [ACC_W-1:0] want;
         if (pending_numbers.size() == 0) begin
            $display("%0t: entered_number expected none, actual %0d", $time, $signed(got));
            errors++;
         end else begin
            want = pending_numbers.pop_front();
            if (got !== want) begin
               $display("%0t: entered_number expected %0d, actual %0d",
                        $time, $signed(want), $signed(got));
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // key_slot_0 .. key_slot_5, 8 bits each
   logic [1:0]  req_tuser = '0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // entered_number

   number_tracker tracker = new();
   int            burst_left = 0;
   int            long_run = 0;
   logic [47:0]   last_sent = '0;

   keyboard_report_number_entry dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver stall pattern, switched among four modes at random
   typedef enum logic [1:0] {
      READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC
   } ready_mode_type;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left = 0;
   logic [3:0]     ready_phase = '0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      ready_phase <= ready_phase + 4'd1;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= ready_phase[2];
      endcase
   end

   // result check at each accepted transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_number(rsp_tdata);
   end

   function automatic logic [KEY_W-1:0] main_digit(input int d);
      return (d == 0) ? KEY_MAIN_0 : 8'(KEY_MAIN_1 + d - 1);
   endfunction

   function automatic logic [KEY_W-1:0] kp_digit(input int d);
      return (d == 0) ? KEY_KP_0 : 8'(KEY_KP_1 + d - 1);
   endfunction

   function automatic logic [47:0] keys6(input logic [KEY_W-1:0] k0, k1, k2, k3, k4, k5);
      return {k5, k4, k3, k2, k1, k0};
   endfunction

   // hold a request until taken, then either carry on the burst or pause
   task automatic send_request(input logic [OP_W-1:0] op, input logic [47:0] keys);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= keys;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      tracker.take_report(op, keys);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(0, 24);
      end
   endtask

   // mostly typing sessions: held keys, new digits, some enters; long runs
   // without enter let the accumulator wrap
   task automatic make_report(output logic [OP_W-1:0] op, output logic [47:0] keys);
      int pick;
      int d;
      int idx;
      logic [KEY_W-1:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 84)
         op = OP_PARSE;
      else if (pick < 91)
         op = OP_RESYNC;
      else if (pick < 97)
         op = OP_CLEAR;
      else
         op = OP_UNUSED;
      if (long_run > 0)
         long_run--;
      else if ($urandom_range(0, 39) == 0)
         long_run = $urandom_range(10, 30);
      for (int i = 0; i < INPUT_SLOTS; i++) begin
         pick = $urandom_range(0, 99);
         d    = $urandom_range(0, 9);
         idx  = $urandom_range(0, INPUT_SLOTS - 1);
         if (pick < 25)
            code = KEY_NONE;
         else if (pick < 45)
            code = last_sent[8*idx +: 8];
         else if (pick < 58)
            code = main_digit(d);
         else if (pick < 70)
            code = kp_digit(d);
         else if (pick < 77)
            code = KEY_BACKSPACE;
         else if (pick < 82 && long_run == 0)
            code = $urandom_range(0, 1) ? KEY_ENTER : KEY_KP_ENTER;
         else
            code = 8'($urandom_range(0, 255));
         keys[8*i +: 8] = code;
      end
      if (op == OP_PARSE || op == OP_RESYNC)
         last_sent = keys;
   endtask

   // watchdog
   initial begin
      #20_000_000;
      $display("keyboard_report_number_entry_tb: errors");
      $finish;
   end

   initial begin
      int              drain;
      logic [OP_W-1:0] op;
      logic [47:0]     keys;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: plain entry, held keys ignored, keypad keys, digits after enter
      send_request(OP_CLEAR, keys6(KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK));
      send_request(OP_PARSE, keys6(main_digit(1), main_digit(2), main_digit(3),
                                   KEY_NONE, KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(main_digit(1), main_digit(2), main_digit(3),
                                   KEY_ENTER, KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(kp_digit(1), kp_digit(2), kp_digit(0), main_digit(0),
                                   KEY_KP_ENTER, main_digit(9)));
      send_request(OP_PARSE, keys6(KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE));
      // same new code twice in one report, then backspace
      send_request(OP_PARSE, keys6(main_digit(4), main_digit(4), KEY_BACKSPACE, main_digit(5),
                                   KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(main_digit(4), main_digit(4), KEY_BACKSPACE, main_digit(5),
                                   KEY_ENTER, KEY_NONE));
      // resync makes keys held, unused op and unknown codes do nothing
      send_request(OP_RESYNC, keys6(kp_digit(9), main_digit(8), KEY_NONE, KEY_NONE,
                                    KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(kp_digit(9), main_digit(8), KEY_ENTER, KEY_NONE,
                                   KEY_NONE, KEY_NONE));
      send_request(OP_UNUSED, keys6(main_digit(1), KEY_ENTER, KEY_NONE, KEY_NONE,
                                    KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK));
      // clear makes previously held keys new again
      send_request(OP_RESYNC, keys6(main_digit(1), KEY_ENTER, KEY_NONE, KEY_NONE,
                                    KEY_NONE, KEY_NONE));
      send_request(OP_CLEAR, keys6(KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK, KEY_JUNK));
      send_request(OP_PARSE, keys6(main_digit(1), KEY_ENTER, KEY_NONE, KEY_NONE,
                                   KEY_NONE, KEY_NONE));
      // twenty-six nines wrap to a negative value, then backspace on it
      for (int r = 0; r < 4; r++) begin
         if (r % 2 == 0)
            send_request(OP_PARSE, keys6(main_digit(9), main_digit(9), main_digit(9),
                                         main_digit(9), main_digit(9), main_digit(9)));
         else
            send_request(OP_PARSE, keys6(kp_digit(9), kp_digit(9), kp_digit(9),
                                         kp_digit(9), kp_digit(9), kp_digit(9)));
      end
      send_request(OP_PARSE, keys6(main_digit(9), main_digit(9), KEY_NONE, KEY_NONE,
                                   KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(KEY_BACKSPACE, KEY_NONE, KEY_NONE, KEY_NONE,
                                   KEY_NONE, KEY_NONE));
      send_request(OP_PARSE, keys6(KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE,
                                   KEY_NONE, KEY_KP_ENTER));
      send_request(OP_PARSE, keys6(KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE));
      // backspace on zero
      send_request(OP_PARSE, keys6(KEY_BACKSPACE, KEY_NONE, KEY_NONE, KEY_NONE,
                                   KEY_NONE, KEY_NONE));

      // random requests
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         make_report(op, keys);
         send_request(op, keys);
      end
      req_tvalid <= 1'b0;

      // drain outstanding numbers, then let the block settle
      drain = 0;
      while (tracker.pending_numbers.size() != 0 && drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending_numbers.size() != 0) begin
         $display("%0t: entered_number expected %0d, actual none (%0d outstanding)", $time,
                  $signed(tracker.pending_numbers[0]), tracker.pending_numbers.size());
         tracker.errors++;
      end

      if (tracker.errors == 0)
         $display("keyboard_report_number_entry_tb: clean");
      else
         $display("keyboard_report_number_entry_tb: errors");
      $finish;
   end

endmodule
